/* rtl/bda_pkg.sv */
// Shared constants for the buddy allocator: sizes, field widths and result codes.
package bda_pkg;

	localparam int ARENA_LOG2_MAX = 12;
	localparam int HEADER_BYTES   = 16;
	localparam int ARENA_LOG2_MIN = 9;
	localparam int ARENA_LOG2_RST = 12;
	localparam int GRAN_LOG2      = 3;

	localparam int FUNC_W   = 1;
	localparam int REQ_W    = 13;
	localparam int FADDR_W  = 12;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = 12;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

endpackage

/* rtl/bda_if.sv */
// Request and response channel interfaces of the buddy allocator.
interface bda_req_if;
	logic                          valid;
	logic                          ready;
	logic [bda_pkg::FUNC_W-1:0]    func;
	logic [bda_pkg::REQ_W-1:0]     req_bytes;
	logic [bda_pkg::FADDR_W-1:0]   free_addr;

	modport source(output valid, func, req_bytes, free_addr, input ready);
	modport sink(input valid, func, req_bytes, free_addr, output ready);
endinterface

interface bda_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bda_pkg::STATUS_W-1:0]  status;
	logic [bda_pkg::ADDR_W-1:0]    addr;

	modport source(output valid, status, addr, input ready);
	modport sink(input valid, status, addr, output ready);
endinterface

/* rtl/bda_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/buddy_allocator_core.sv */
// Buddy allocator over an arena of 2^arena_log2 bytes, one word in and one word out per request.
// The block table (one entry per 8-byte granule) sits in one RAM with registered reads, so
// every table read takes a read state and an evaluate state. An allocate walks every block in
// the arena (best fit), then splits the chosen block in halves down to the needed size before
// it answers; one refused after the walk answers without splitting, and an oversized request
// answers without the walk. A free probes buddies in turn and merges while they are free; a
// free address outside the arena answers without a table read, and one that names no
// allocated block answers after its single table read.
// After reset and after every arena_log2 write the table is cleared in a
// pass over all 2^(ARENA_LOG2_MAX-3) entries (512 by default) during which no request is taken.
// The response register lets a new request start while the previous word waits.
module buddy_allocator_core #(
	parameter int ARENA_LOG2_MAX = bda_pkg::ARENA_LOG2_MAX,
	parameter int HEADER_BYTES   = bda_pkg::HEADER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	bda_req_if.sink     req,
	bda_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int G     = bda_pkg::GRAN_LOG2;
	localparam int AW    = ARENA_LOG2_MAX;
	localparam int SW    = AW - G;
	localparam int SLOTS = 1 << SW;
	localparam int LW    = $clog2(AW + 1);
	localparam int EW    = LW + 2;
	localparam int OW    = AW + 1;
	localparam int TW    = bda_pkg::REQ_W + 1;
	localparam int CW    = (OW > TW) ? OW : TW;
	localparam int RST_L = (bda_pkg::ARENA_LOG2_RST > AW) ? AW : bda_pkg::ARENA_LOG2_RST;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_A_RD  = 4'd2;
	localparam logic [3:0] S_A_EV  = 4'd3;
	localparam logic [3:0] S_A_DEC = 4'd4;
	localparam logic [3:0] S_A_SPL = 4'd5;
	localparam logic [3:0] S_F_RD  = 4'd6;
	localparam logic [3:0] S_F_CHK = 4'd7;
	localparam logic [3:0] S_M_RD  = 4'd8;
	localparam logic [3:0] S_M_EV  = 4'd9;
	localparam logic [3:0] S_F_FIN = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0]    state_q;
	logic [LW-1:0] alog_q;
	logic [SW-1:0] clr_q;
	logic [OW-1:0] off_q;
	logic [LW-1:0] lg_q;
	logic [LW-1:0] need_q;
	logic [AW-1:0] best_q;
	logic [LW-1:0] best_log_q;
	logic          found_q;
	logic [1:0]    cnt_q;
	logic [bda_pkg::STATUS_W-1:0] res_status_q;
	logic [bda_pkg::ADDR_W-1:0]   res_addr_q;
	logic          rsp_valid_q;
	logic [bda_pkg::STATUS_W-1:0] rsp_status_q;
	logic [bda_pkg::ADDR_W-1:0]   rsp_addr_q;

	logic          cfg_we;
	logic [LW-1:0] cfg_log;
	logic [OW-1:0] arena;
	logic [CW-1:0] total;
	logic [CW-1:0] fa;
	logic [CW-1:0] foff;
	logic [LW-1:0] need_c;
	logic [AW-1:0] cur;
	logic [AW-1:0] bit_lg;
	logic [AW-1:0] bud;
	logic [AW-1:0] split_bit;

	logic          ram_we;
	logic [SW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [SW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	logic          rd_start;
	logic          rd_free;
	logic [LW-1:0] rd_log;
	logic          out_load;

	assign pready = 1'b1;
	assign prdata = 32'(alog_q);
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		if (pwdata[3:0] < 4'(bda_pkg::ARENA_LOG2_MIN)) begin
			cfg_log = LW'(bda_pkg::ARENA_LOG2_MIN);
		end else if (32'(pwdata[3:0]) > AW) begin
			cfg_log = LW'(AW);
		end else begin
			cfg_log = LW'(pwdata[3:0]);
		end
	end

	assign arena     = OW'(1) << alog_q;
	assign total     = CW'(req.req_bytes) + CW'(HEADER_BYTES);
	assign fa        = CW'(req.free_addr);
	assign foff      = fa - CW'(HEADER_BYTES);
	assign cur       = off_q[AW-1:0];
	assign bit_lg    = AW'(1) << lg_q;
	assign bud       = cur ^ bit_lg;
	assign split_bit = AW'(1) << (best_log_q - LW'(1));

	// Smallest power of two, at least one granule, that holds request plus header.
	always_comb begin
		need_c = LW'(G);
		for (int k = AW; k >= G; k--) begin
			if ((CW'(1) << k) >= total) begin
				need_c = LW'(k);
			end
		end
	end

	assign rd_start = ram_rdata[EW-1];
	assign rd_free  = ram_rdata[EW-2];
	assign rd_log   = ram_rdata[LW-1:0];

	always_comb begin
		case (state_q)
			S_M_RD:  ram_raddr = bud[AW-1:G];
			default: ram_raddr = cur[AW-1:G];
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur[AW-1:G];
		ram_wdata = '0;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == '0) ? {2'b11, alog_q} : '0;
			end
			S_A_SPL: begin
				ram_we = 1'b1;
				if (best_log_q > need_q) begin
					ram_waddr = SW'((best_q | split_bit) >> G);
					ram_wdata = {2'b11, best_log_q - LW'(1)};
				end else begin
					ram_waddr = best_q[AW-1:G];
					ram_wdata = {2'b10, need_q};
				end
			end
			S_M_EV: begin
				// The upper half of a merged pair stops being a block.
				ram_we    = rd_start && rd_free && (rd_log == lg_q);
				ram_waddr = SW'((cur | bit_lg) >> G);
				ram_wdata = '0;
			end
			S_F_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = cur[AW-1:G];
				ram_wdata = {2'b11, lg_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bda_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req.ready  = (state_q == S_IDLE);
	assign out_load   = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.addr   = rsp_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			alog_q      <= LW'(RST_L);
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				alog_q  <= cfg_log;
				clr_q   <= '0;
				state_q <= S_CLR;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (req.valid) begin
							if (req.func == bda_pkg::FUNC_ALLOC) begin
								state_q <= (total > CW'(arena)) ? S_DONE : S_A_RD;
							end else if (fa < CW'(HEADER_BYTES) || foff >= CW'(arena)
									|| foff[G-1:0] != '0) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_F_RD;
							end
						end
					end
					S_CLR: begin
						clr_q <= clr_q + SW'(1);
						if (clr_q == SW'(SLOTS - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_A_RD:  state_q <= (off_q >= arena) ? S_A_DEC : S_A_EV;
					S_A_EV:  state_q <= S_A_RD;
					S_A_DEC: begin
						if (!found_q || (cnt_q == 2'd1 && best_log_q == need_q)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_A_SPL;
						end
					end
					S_A_SPL: begin
						if (best_log_q <= need_q) begin
							state_q <= S_DONE;
						end
					end
					S_F_RD: state_q <= S_F_CHK;
					S_F_CHK: begin
						if (!rd_start || rd_free) begin
							state_q <= S_DONE;
						end else begin
							state_q <= (rd_log < alog_q) ? S_M_RD : S_F_FIN;
						end
					end
					S_M_RD: state_q <= S_M_EV;
					S_M_EV: begin
						if (rd_start && rd_free && rd_log == lg_q
								&& (lg_q + LW'(1)) < alog_q) begin
							state_q <= S_M_RD;
						end else begin
							state_q <= S_F_FIN;
						end
					end
					S_F_FIN: state_q <= S_DONE;
					S_DONE: begin
						if (out_load) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_status_q <= res_status_q;
			rsp_addr_q   <= res_addr_q;
		end
		case (state_q)
			S_IDLE: begin
				res_addr_q <= '0;
				off_q      <= '0;
				found_q    <= 1'b0;
				cnt_q      <= 2'd0;
				need_q     <= need_c;
				if (req.func == bda_pkg::FUNC_ALLOC) begin
					res_status_q <= bda_pkg::ST_NOFIT;
				end else begin
					res_status_q <= bda_pkg::ST_BAD_FREE;
					off_q        <= foff[OW-1:0];
				end
			end
			S_A_EV: begin
				if (rd_free) begin
					if (cnt_q != 2'd2) begin
						cnt_q <= cnt_q + 2'd1;
					end
					if (rd_log >= need_q && (!found_q || rd_log < best_log_q)) begin
						found_q    <= 1'b1;
						best_q     <= cur;
						best_log_q <= rd_log;
					end
				end
				off_q <= off_q + (OW'(1) << rd_log);
			end
			S_A_SPL: begin
				if (best_log_q > need_q) begin
					best_log_q <= best_log_q - LW'(1);
				end else begin
					res_status_q <= bda_pkg::ST_OK;
					res_addr_q   <= bda_pkg::ADDR_W'(CW'(best_q) + CW'(HEADER_BYTES));
				end
			end
			S_F_CHK: lg_q <= rd_log;
			S_M_EV: begin
				if (rd_start && rd_free && rd_log == lg_q) begin
					off_q <= OW'(cur & ~bit_lg);
					lg_q  <= lg_q + LW'(1);
				end
			end
			S_F_FIN: res_status_q <= bda_pkg::ST_OK;
			default: begin
			end
		endcase
	end

	a_split_above_need: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_SPL |-> best_log_q >= need_q)
		else $error("split went below the needed block size");

	a_nok_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q != bda_pkg::ST_OK |-> rsp_addr_q == '0)
		else $error("refused request carries a nonzero address");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response word loaded outside the done state");

	a_merge_in_arena: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_M_EV |-> lg_q < alog_q)
		else $error("buddy merge beyond the arena size");

endmodule

/* tb/bda_checker.sv */
// Checker for the buddy allocator: watches both channels, predicts every response and compares.
module bda_checker (
	input  logic        clk,
	input  logic        arst_n,
	bda_req_if.sink     req_mon,
	bda_rsp_if.sink     rsp_mon,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_val,
	output int          fail_count,
	output int          pending
);

	localparam int SLOTS = 1 << (bda_pkg::ARENA_LOG2_MAX - bda_pkg::GRAN_LOG2);

	typedef struct packed {
		logic [bda_pkg::STATUS_W-1:0] status;
		logic [bda_pkg::ADDR_W-1:0]   addr;
	} rsp_word_t;

	bit       blk_start[SLOTS];
	bit       blk_free[SLOTS];
	bit [4:0] blk_log[SLOTS];
	int unsigned arena_lg;
	rsp_word_t exp_words[$];

	initial fail_count = 0;
	assign pending = exp_words.size();

	function automatic int unsigned sat_log(int unsigned v);
		if (v < bda_pkg::ARENA_LOG2_MIN) return bda_pkg::ARENA_LOG2_MIN;
		if (v > bda_pkg::ARENA_LOG2_MAX) return bda_pkg::ARENA_LOG2_MAX;
		return v;
	endfunction

	task automatic clear_arena(int unsigned lg);
		arena_lg = sat_log(lg);
		for (int i = 0; i < SLOTS; i++) begin
			blk_start[i] = 0;
			blk_free[i] = 0;
			blk_log[i] = 0;
		end
		blk_start[0] = 1;
		blk_free[0] = 1;
		blk_log[0] = 5'(arena_lg);
	endtask

	function automatic rsp_word_t predict_alloc(int unsigned n);
		int unsigned arena_sz, total, need, off, cnt, best, best_lg, s, lg;
		bit found;
		rsp_word_t w;
		w.status = bda_pkg::ST_NOFIT;
		w.addr = '0;
		arena_sz = 1 << arena_lg;
		total = n + bda_pkg::HEADER_BYTES;
		if (total > arena_sz) return w;
		need = 0;
		while ((1 << need) < total) need++;
		if (need < bda_pkg::GRAN_LOG2) need = bda_pkg::GRAN_LOG2;
		off = 0; cnt = 0; found = 0; best = 0; best_lg = 0;
		while (off < arena_sz) begin
			s = (off >> bda_pkg::GRAN_LOG2) & (SLOTS - 1);
			lg = blk_log[s];
			if (blk_free[s]) begin
				cnt++;
				if (lg >= need && (!found || lg < best_lg)) begin
					found = 1; best = off; best_lg = lg;
				end
			end
			off += 1 << lg;
		end
		if (!found) return w;
		// The last free block is never handed out whole.
		if (cnt == 1 && best_lg == need) return w;
		while (best_lg > need) begin
			best_lg--;
			s = (best + (1 << best_lg)) >> bda_pkg::GRAN_LOG2;
			blk_start[s] = 1;
			blk_free[s] = 1;
			blk_log[s] = 5'(best_lg);
		end
		blk_log[best >> bda_pkg::GRAN_LOG2] = 5'(best_lg);
		blk_free[best >> bda_pkg::GRAN_LOG2] = 0;
		w.status = bda_pkg::ST_OK;
		w.addr = bda_pkg::ADDR_W'(best + bda_pkg::HEADER_BYTES);
		return w;
	endfunction

	function automatic rsp_word_t predict_free(int unsigned fa);
		int unsigned off, s, lg, bud, bs, lo, hi;
		rsp_word_t w;
		w.status = bda_pkg::ST_BAD_FREE;
		w.addr = '0;
		if (fa < bda_pkg::HEADER_BYTES) return w;
		off = fa - bda_pkg::HEADER_BYTES;
		if (off >= (1 << arena_lg) || (off & ((1 << bda_pkg::GRAN_LOG2) - 1)) != 0) return w;
		s = off >> bda_pkg::GRAN_LOG2;
		if (!blk_start[s] || blk_free[s]) return w;
		lg = blk_log[s];
		blk_free[s] = 1;
		while (lg < arena_lg) begin
			bud = off ^ (1 << lg);
			bs = (bud >> bda_pkg::GRAN_LOG2) & (SLOTS - 1);
			if (!(blk_start[bs] && blk_free[bs] && blk_log[bs] == lg)) break;
			lo = off < bud ? off : bud;
			hi = off < bud ? bud : off;
			blk_start[hi >> bda_pkg::GRAN_LOG2] = 0;
			blk_free[hi >> bda_pkg::GRAN_LOG2] = 0;
			blk_log[hi >> bda_pkg::GRAN_LOG2] = 0;
			off = lo;
			lg++;
			blk_log[off >> bda_pkg::GRAN_LOG2] = 5'(lg);
			blk_free[off >> bda_pkg::GRAN_LOG2] = 1;
		end
		w.status = bda_pkg::ST_OK;
		return w;
	endfunction

	task automatic report(string what, rsp_word_t got, rsp_word_t want);
		$display("%0t: %s: got status %0d addr %0d, want status %0d addr %0d",
			$time, what, got.status, got.addr, want.status, want.addr);
		fail_count++;
	endtask

	initial clear_arena(bda_pkg::ARENA_LOG2_RST);

	always @(posedge clk) begin
		rsp_word_t got, want;
		if (arst_n) begin
			if (cfg_we)
				clear_arena(cfg_val);
			if (rsp_mon.valid && rsp_mon.ready) begin
				got.status = rsp_mon.status;
				got.addr = rsp_mon.addr;
				if (exp_words.size() == 0) begin
					report("unexpected word", got, got);
				end else begin
					want = exp_words.pop_front();
					if (got.status != want.status)
						report("status mismatch", got, want);
					else if (got.addr != want.addr)
						report("addr mismatch", got, want);
				end
			end
			if (req_mon.valid && req_mon.ready) begin
				if (req_mon.func == bda_pkg::FUNC_ALLOC)
					exp_words.push_back(predict_alloc(req_mon.req_bytes));
				else
					exp_words.push_back(predict_free(req_mon.free_addr));
			end
		end
	end
endmodule

/* tb/buddy_allocator_core_tb.sv */
// Top of the buddy allocator testbench: clock, reset, stimulus, register writes and verdict.
module buddy_allocator_core_tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        cfg_we;
	int          fail_count, pending;
	int          rsp_hold = 0;
	bit          stall_mode = 0;
	int          n_alloc = 0, n_free = 0;
	logic [bda_pkg::ADDR_W-1:0] live_addrs[$];

	bda_req_if req_ch();
	bda_rsp_if rsp_ch();

	buddy_allocator_core DUT (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	assign cfg_we = psel && penable && pwrite && pready && paddr == 2'd0;

	bda_checker u_chk (
		.clk(clk), .arst_n(arst_n), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
		.cfg_we(cfg_we), .cfg_val(pwdata[3:0]), .fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		req_ch.valid = 0;
		req_ch.func = bda_pkg::FUNC_ALLOC;
		req_ch.req_bytes = '0;
		req_ch.free_addr = '0;
		rsp_ch.ready = 0;
	end

	// Receiver: random stalls, plus a long hold-off when rsp_hold is set.
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_hold <= rsp_hold - 1;
			rsp_ch.ready <= 0;
		end else if (stall_mode)
			rsp_ch.ready <= ($urandom_range(0, 3) == 0);
		else
			rsp_ch.ready <= 1;
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= ~stall_mode;
	end

	task automatic cfg_write(logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'd0; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		live_addrs.delete();
	endtask

	task automatic send_word(logic [bda_pkg::FUNC_W-1:0] f, int unsigned nb, int unsigned fa);
		req_ch.valid <= 1;
		req_ch.func <= f;
		req_ch.req_bytes <= bda_pkg::REQ_W'(nb);
		req_ch.free_addr <= bda_pkg::FADDR_W'(fa);
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (f == bda_pkg::FUNC_ALLOC) n_alloc++; else n_free++;
	endtask

	task automatic drain();
		req_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// A clearing pass or late walk may still be in flight.
		repeat (2200) @(posedge clk);
	endtask

	// A mix of mostly small allocations and frees of addresses handed out earlier or picked at random.
	task automatic random_burst(int unsigned count);
		int unsigned k, nb, fa, gap, burst, idx;
		burst = 0;
		for (k = 0; k < count; k++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
				req_ch.valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst--;
			if ($urandom_range(0, 1) == 0 || live_addrs.size() == 0) begin
				case ($urandom_range(0, 9))
					0: nb = $urandom_range(0, 8191);
					1, 2: nb = $urandom_range(0, 1024);
					default: nb = $urandom_range(0, 120);
				endcase
				send_word(bda_pkg::FUNC_ALLOC, nb, $urandom_range(0, 4095));
				if ($urandom_range(0, 1) == 0)
					live_addrs.push_back(bda_pkg::FADDR_W'(16 + 8 * $urandom_range(0, 511)));
			end else begin
				if ($urandom_range(0, 7) == 0)
					fa = $urandom_range(0, 4095);
				else begin
					idx = $urandom_range(0, live_addrs.size() - 1);
					fa = live_addrs[idx];
					if ($urandom_range(0, 3) != 0)
						live_addrs.delete(idx);
				end
				send_word(bda_pkg::FUNC_FREE, 0, fa);
			end
		end
	endtask

	// Capture allocated addresses so later frees mostly hit real blocks.
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == bda_pkg::ST_OK
				&& rsp_ch.addr != 0)
			live_addrs.push_back(rsp_ch.addr);
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		// Directed part on the reset arena.
		send_word(bda_pkg::FUNC_ALLOC, 4096, 0);
		send_word(bda_pkg::FUNC_ALLOC, 8191, 0);
		send_word(bda_pkg::FUNC_ALLOC, 4080, 0);
		send_word(bda_pkg::FUNC_ALLOC, 4079, 0);
		send_word(bda_pkg::FUNC_ALLOC, 0, 0);
		send_word(bda_pkg::FUNC_ALLOC, 16, 0);
		send_word(bda_pkg::FUNC_ALLOC, 2032, 0);
		send_word(bda_pkg::FUNC_FREE, 0, 0);
		send_word(bda_pkg::FUNC_FREE, 0, 15);
		send_word(bda_pkg::FUNC_FREE, 0, 20);
		send_word(bda_pkg::FUNC_FREE, 0, 4095);
		send_word(bda_pkg::FUNC_FREE, 0, 16);
		send_word(bda_pkg::FUNC_FREE, 0, 16);
		send_word(bda_pkg::FUNC_FREE, 0, 32);
		send_word(bda_pkg::FUNC_FREE, 0, 48);
		send_word(bda_pkg::FUNC_FREE, 0, 2048 + 16);
		drain();
		cfg_write(32'd9);
		send_word(bda_pkg::FUNC_ALLOC, 497, 0);
		send_word(bda_pkg::FUNC_ALLOC, 496, 0);
		send_word(bda_pkg::FUNC_ALLOC, 240, 0);
		send_word(bda_pkg::FUNC_FREE, 0, 16);
		send_word(bda_pkg::FUNC_FREE, 0, 528);
		drain();
		cfg_write(32'd0);
		random_burst(200);
		// Long receiver hold-off while requests keep coming.
		rsp_hold <= 3000;
		random_burst(150);
		drain();
		cfg_write(32'd15);
		random_burst(300);
		drain();
		cfg_write(32'd10);
		random_burst(300);
		drain();
		cfg_write(32'd11);
		random_burst(250);
		drain();
		cfg_write(32'd12);
		random_burst(300);
		drain();
		$display("Covered %0d allocate and %0d free requests over arena sizes 512 to 4096.",
			n_alloc, n_free);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#200000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
